// File: rtl/snf_pkg.sv
// Shared types and constants for the spiking neuron with fanout.
// Holds the item and spike payload structs, operation and register codes.
// No dependencies.
package snf_pkg;

  localparam int MAX_LINKS   = 8;
  localparam int LINK_AW     = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_W         = 16;
  localparam int LEAK_W      = 15;
  localparam int REFR_W      = 8;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [1:0] {
    OP_RECEIVE  = 2'd0,
    OP_TICK     = 2'd1,
    OP_SET_LINK = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESTING_LEVEL    = 3'd0,
    REG_LEAK_STEP        = 3'd1,
    REG_FIRE_THRESHOLD   = 3'd2,
    REG_REFRACTORY_TICKS = 3'd3,
    REG_TICK_DRIVEN      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic signed [Q_W-1:0] amount;
    logic [2:0]            link_index;
  } item_t;

  typedef struct packed {
    logic [2:0]            target_index;
    logic signed [Q_W-1:0] spike_weight;
    logic                  last;
  } spike_t;

  typedef logic [MAX_LINKS-1:0] link_mask_t;
  typedef logic [LINK_AW-1:0]   link_addr_t;

  // Reasons for the front end to hold off new items.
  typedef struct packed {
    logic full;   // fire queue has no room
    logic busy;   // a firing is queued or being walked: link table must not change
  } front_hold_t;

  // Link table write from the front end.
  typedef struct packed {
    logic                  we;
    link_addr_t            addr;
    logic signed [Q_W-1:0] data;
  } link_wr_t;

endpackage

// File: rtl/snf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module snf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/snf_front.sv
// Front end: accepts items, keeps potential, refractory count, link valid
// bits and configuration; writes the link table and queues firings.
// Depends on snf_pkg.
module snf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  snf_pkg::item_t                      item,
  input  logic                                cfg_we,
  input  logic [snf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [snf_pkg::Q_W-1:0]             cfg_data,
  input  snf_pkg::front_hold_t                hold,
  output logic                                fire_push,
  output snf_pkg::link_mask_t                 fire_mask,
  output snf_pkg::link_wr_t                   link_wr
);

  logic signed [snf_pkg::Q_W-1:0]    resting_level;
  logic [snf_pkg::LEAK_W-1:0]        leak_step;
  logic signed [snf_pkg::Q_W-1:0]    fire_threshold;
  logic [snf_pkg::REFR_W-1:0]        refractory_ticks;
  logic                              tick_driven;

  logic signed [snf_pkg::Q_W-1:0]    potential, potential_next;
  logic [snf_pkg::REFR_W-1:0]        refractory_left, refractory_left_next;
  snf_pkg::link_mask_t               link_valid, link_valid_next;

  logic                              accept;
  logic                              is_set;
  logic                              fire;
  logic signed [snf_pkg::Q_W:0]      sum;
  logic signed [snf_pkg::Q_W-1:0]    rx_pot;
  logic signed [snf_pkg::Q_W+1:0]    leak_dn, leak_up, rest_x;

  assign is_set     = (item.operation == snf_pkg::OP_SET_LINK);
  assign item_ready = !hold.full && !(is_set && hold.busy);
  assign accept     = item_valid && item_ready;

  always_comb begin
    sum = {potential[snf_pkg::Q_W-1], potential} + {item.amount[snf_pkg::Q_W-1], item.amount};
    if (sum[snf_pkg::Q_W] != sum[snf_pkg::Q_W-1]) begin
      rx_pot = sum[snf_pkg::Q_W] ? {1'b1, {(snf_pkg::Q_W-1){1'b0}}}
                                 : {1'b0, {(snf_pkg::Q_W-1){1'b1}}};
    end else begin
      rx_pot = sum[snf_pkg::Q_W-1:0];
    end
    rest_x  = {{2{resting_level[snf_pkg::Q_W-1]}}, resting_level};
    leak_dn = {{2{potential[snf_pkg::Q_W-1]}}, potential} - {3'b000, leak_step};
    leak_up = {{2{potential[snf_pkg::Q_W-1]}}, potential} + {3'b000, leak_step};
  end

  always_comb begin
    potential_next       = potential;
    refractory_left_next = refractory_left;
    link_valid_next      = link_valid;
    fire                 = 1'b0;
    link_wr.we           = 1'b0;
    link_wr.addr         = snf_pkg::LINK_AW'(item.link_index);
    link_wr.data         = item.amount;
    if (accept) begin
      case (item.operation)
        snf_pkg::OP_RECEIVE: begin
          potential_next = rx_pot;
          if (!tick_driven && !(rx_pot < fire_threshold)) begin
            if (refractory_left == '0) begin
              fire = 1'b1;
            end else begin
              refractory_left_next = refractory_left - 1'b1;
            end
          end
        end
        snf_pkg::OP_TICK: begin
          if (refractory_left != '0) begin
            refractory_left_next = refractory_left - 1'b1;
          end else if (potential > fire_threshold) begin
            fire = 1'b1;
          end else if (potential > resting_level) begin
            potential_next = (leak_dn < rest_x) ? resting_level : leak_dn[snf_pkg::Q_W-1:0];
          end else if (potential < resting_level) begin
            potential_next = (leak_up > rest_x) ? resting_level : leak_up[snf_pkg::Q_W-1:0];
          end
        end
        snf_pkg::OP_SET_LINK: begin
          if (int'(item.link_index) < snf_pkg::MAX_LINKS) begin
            link_wr.we = 1'b1;
            link_valid_next[snf_pkg::LINK_AW'(item.link_index)] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (fire) begin
      refractory_left_next = refractory_ticks;
    end
  end

  // A firing with no valid links emits nothing, so it never enters the queue.
  assign fire_push = fire && (link_valid != '0);
  assign fire_mask = link_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      resting_level    <= '0;
      leak_step        <= snf_pkg::LEAK_W'(256);
      fire_threshold   <= '0;
      refractory_ticks <= '0;
      tick_driven      <= 1'b0;
      potential        <= '0;
      refractory_left  <= '0;
      link_valid       <= '0;
    end else begin
      potential       <= potential_next;
      refractory_left <= refractory_left_next;
      link_valid      <= link_valid_next;
      if (cfg_we) begin
        case (cfg_index)
          snf_pkg::REG_RESTING_LEVEL:    resting_level    <= cfg_data;
          snf_pkg::REG_LEAK_STEP:        leak_step        <= cfg_data[snf_pkg::LEAK_W-1:0];
          snf_pkg::REG_FIRE_THRESHOLD:   fire_threshold   <= cfg_data;
          snf_pkg::REG_REFRACTORY_TICKS: refractory_ticks <= cfg_data[snf_pkg::REFR_W-1:0];
          snf_pkg::REG_TICK_DRIVEN:      tick_driven      <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/snf_queue.sv
// Short queue of firing commands (valid link masks) between front and back.
// Depends on snf_pkg.
module snf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  snf_pkg::link_mask_t push_data,
  input  logic                pop,
  output snf_pkg::link_mask_t pop_data,
  output logic                empty,
  output logic                full
);

  localparam int PTR_W = (snf_pkg::QUEUE_DEPTH > 1) ? $clog2(snf_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(snf_pkg::QUEUE_DEPTH + 1);

  snf_pkg::link_mask_t entries [snf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    head, tail;
  logic [CNT_W-1:0]    count;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(snf_pkg::QUEUE_DEPTH));
  assign pop_data = entries[head];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(snf_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        tail <= wrap_inc(tail);
      end
      if (pop && !empty) begin
        head <= wrap_inc(head);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/snf_back.sv
// Back end: walks the valid links of each queued firing in index order,
// reads each weight from the link table and presents one spike per link.
// Depends on snf_pkg.
module snf_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  snf_pkg::link_mask_t            q_data,
  output logic                           q_pop,
  output logic                           ram_re,
  output snf_pkg::link_addr_t            ram_raddr,
  input  logic [snf_pkg::Q_W-1:0]        ram_rdata,
  output logic                           walking,
  output logic                           active,
  output logic                           spike_valid,
  input  logic                           spike_ready,
  output snf_pkg::spike_t                spike
);

  snf_pkg::link_mask_t pend, pend_next, rest;
  logic                have_data;
  snf_pkg::link_addr_t hold_idx;
  logic                hold_last;
  snf_pkg::link_addr_t pick;
  logic                out_free;
  logic                move;
  logic                issue;

  // Lowest set bit of the pending mask.
  always_comb begin
    pick = '0;
    for (int i = snf_pkg::MAX_LINKS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        pick = snf_pkg::LINK_AW'(i);
      end
    end
  end

  assign rest      = pend & ~(snf_pkg::link_mask_t'(1) << pick);
  assign out_free  = !spike_valid || spike_ready;
  assign move      = have_data && out_free;
  assign issue     = (pend != '0) && (!have_data || move);
  assign q_pop     = (pend == '0) && !q_empty;
  assign ram_re    = issue;
  assign ram_raddr = pick;
  assign walking   = (pend != '0);
  assign active    = (pend != '0) || have_data;

  always_comb begin
    pend_next = pend;
    if (issue) begin
      pend_next = rest;
    end else if (q_pop) begin
      pend_next = q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      hold_idx  <= pick;
      hold_last <= (rest == '0);
    end
    if (move) begin
      spike.target_index <= 3'(hold_idx);
      spike.spike_weight <= ram_rdata;
      spike.last         <= hold_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend        <= '0;
      have_data   <= 1'b0;
      spike_valid <= 1'b0;
    end else begin
      pend <= pend_next;
      if (issue) begin
        have_data <= 1'b1;
      end else if (move) begin
        have_data <= 1'b0;
      end
      if (move) begin
        spike_valid <= 1'b1;
      end else if (spike_ready) begin
        spike_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/spiking_neuron_with_fanout.sv
// Top level of the leaky integrate-and-fire neuron with an outgoing link table.
// Instantiates snf_front, snf_queue, snf_back and snf_ram; uses snf_pkg.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------------
//   item     | item_valid / item_ready    | snf_pkg::item_t (operation, amount, link)
//   spike    | spike_valid / spike_ready  | snf_pkg::spike_t (target, weight, last)
//   config   | cfg_we (no wait)           | cfg_index 3 bits, cfg_data 16 bits
//
// Flow: the front end takes one item per cycle while item_ready is high. A firing with
// n valid links gives n spikes, one per cycle while spike_ready is high, a table read each.
// Reset: rst is synchronous and clears potential, refractory count, link valid
// bits, queue and back end; link weights are not cleared (read only when valid).
// Stalls: item_ready drops when the fire queue is full, and for a set-link item
// while a firing still waits in the queue or is being walked.
module spiking_neuron_with_fanout (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  snf_pkg::item_t                item,
  output logic                          spike_valid,
  input  logic                          spike_ready,
  output snf_pkg::spike_t               spike,
  input  logic                          cfg_we,
  input  logic [snf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [snf_pkg::Q_W-1:0]       cfg_data
);

  snf_pkg::front_hold_t     hold;
  logic                     fire_push;
  snf_pkg::link_mask_t      fire_mask;
  snf_pkg::link_wr_t        link_wr;
  logic                     q_pop;
  snf_pkg::link_mask_t      q_data;
  logic                     q_empty;
  logic                     q_full;
  logic                     ram_re;
  snf_pkg::link_addr_t      ram_raddr;
  logic [snf_pkg::Q_W-1:0]  ram_rdata;
  logic                     back_walking;
  logic                     back_active;

  // Hold new items while the queue is full; hold link writes while a walk
  // could still read the table.
  assign hold.full = q_full;
  assign hold.busy = !q_empty || back_walking;

  snf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .hold       (hold),
    .fire_push  (fire_push),
    .fire_mask  (fire_mask),
    .link_wr    (link_wr)
  );

  snf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fire_push),
    .push_data (fire_mask),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Link weight table: written by the front end, read by the back end.
  snf_ram #(
    .WIDTH (snf_pkg::Q_W),
    .DEPTH (snf_pkg::MAX_LINKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_wr.we),
    .waddr (link_wr.addr),
    .wdata (link_wr.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  snf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .walking     (back_walking),
    .active      (back_active),
    .spike_valid (spike_valid),
    .spike_ready (spike_ready),
    .spike       (spike)
  );

  // Never push a firing into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fire_push |-> !q_full)
    else $error("fire queue overflow");

  // Never change the link table while a firing is pending or being walked.
  a_table_stable: assert property (@(posedge clk) disable iff (rst)
    link_wr.we |-> (q_empty && !back_walking))
    else $error("link table written during a walk");

  // A spike that is not the last of its firing has a successor on the way.
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (spike_valid && spike_ready && !spike.last) |=> (spike_valid || back_active))
    else $error("firing burst ended without a last spike");

endmodule

// File: sim/tb_spiking_neuron_with_fanout.sv
// Self-checking testbench for the spiking neuron with fanout: integration,
// leak, refractory count, link table and spike fanout against a local model.
// Depends on snf_pkg and the spiking_neuron_with_fanout RTL.
module tb_spiking_neuron_with_fanout;
  timeunit 1ns;
  timeprecision 1ps;

  // Margin after the last expected spike before touching config, so that
  // nothing is left in flight in the back end.
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_PCT      = 37;

  logic                          clk;
  logic                          rst         = 1'b1;
  logic                          item_valid  = 1'b0;
  logic                          item_ready;
  snf_pkg::item_t                item        = '0;
  logic                          spike_valid;
  logic                          spike_ready = 1'b0;
  snf_pkg::spike_t               spike;
  logic                          cfg_we      = 1'b0;
  logic [snf_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
  logic [snf_pkg::Q_W-1:0]       cfg_data    = '0;

  // Turn off random idling on both channels for a stretch.
  bit no_idle = 1'b0;
  int errors  = 0;

  // Local copy of the configuration, at reset values.
  logic signed [snf_pkg::Q_W-1:0] m_rest        = '0;
  logic [snf_pkg::LEAK_W-1:0]     m_leak        = 15'd256;
  logic signed [snf_pkg::Q_W-1:0] m_thr         = '0;
  logic [snf_pkg::REFR_W-1:0]     m_refr_ticks  = '0;
  logic                           m_tick_driven = 1'b0;

  // Local copy of the neuron state.
  logic signed [snf_pkg::Q_W-1:0] m_pot       = '0;
  logic [snf_pkg::REFR_W-1:0]     m_refr_left = '0;
  logic signed [snf_pkg::Q_W-1:0] m_weight [snf_pkg::MAX_LINKS] = '{default: '0};
  logic                           m_linked [snf_pkg::MAX_LINKS] = '{default: 1'b0};

  // Spikes predicted but not yet seen on the spike channel, oldest first.
  snf_pkg::spike_t pending_spikes [$];

  spiking_neuron_with_fanout dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .spike_valid(spike_valid),
    .spike_ready(spike_ready),
    .spike      (spike),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver side: drop ready at random unless the no-idle stretch is on.
  always @(posedge clk) begin
    spike_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Walk the link table in index order, queue one spike per valid link,
  // flag the final one, then reload the refractory count.
  task automatic fire_links();
    snf_pkg::spike_t s;
    int              last_i;
    last_i = -1;
    for (int i = 0; i < snf_pkg::MAX_LINKS; i++) begin
      if (m_linked[i]) last_i = i;
    end
    for (int i = 0; i < snf_pkg::MAX_LINKS; i++) begin
      if (m_linked[i]) begin
        s.target_index = 3'(i);
        s.spike_weight = m_weight[i];
        s.last         = (i == last_i);
        pending_spikes.push_back(s);
      end
    end
    m_refr_left = m_refr_ticks;
  endtask

  // Advance the neuron state by one item and queue the spikes it causes.
  task automatic integrate_item(input snf_pkg::item_t it);
    int acc;
    case (snf_pkg::op_t'(it.operation))
      snf_pkg::OP_RECEIVE: begin
        // Saturate the sum to the Q8.8 range.
        acc = int'(m_pot) + int'($signed(it.amount));
        if (acc > 32767) m_pot = 16'sh7FFF;
        else if (acc < -32768) m_pot = 16'sh8000;
        else m_pot = 16'(acc);
        // Receive fires only when not tick-driven and at or above threshold.
        if (!m_tick_driven && m_pot >= m_thr) begin
          if (m_refr_left == 0) fire_links();
          else m_refr_left--;
        end
      end
      snf_pkg::OP_TICK: begin
        if (m_refr_left != 0) begin
          m_refr_left--;
        end else if (m_pot > m_thr) begin
          fire_links();
        end else if (m_pot > m_rest) begin
          // Leak down, clamp at rest.
          acc = int'(m_pot) - int'(m_leak);
          m_pot = (acc < int'(m_rest)) ? m_rest : 16'(acc);
        end else if (m_pot < m_rest) begin
          // Leak up, clamp at rest.
          acc = int'(m_pot) + int'(m_leak);
          m_pot = (acc > int'(m_rest)) ? m_rest : 16'(acc);
        end
      end
      snf_pkg::OP_SET_LINK: begin
        if (int'(it.link_index) < snf_pkg::MAX_LINKS) begin
          m_weight[it.link_index] = it.amount;
          m_linked[it.link_index] = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // Sample both channels at the falling edge, where inputs and outputs are
  // stable until the next rising edge. Predict before checking so a spike
  // can never be compared ahead of the item that causes it.
  always @(negedge clk) begin
    snf_pkg::spike_t want;
    if (!rst) begin
      if (item_valid && item_ready) integrate_item(item);
      if (spike_valid && spike_ready) begin
        if (pending_spikes.size() == 0) begin
          $error("unexpected spike: target_index %0d spike_weight %0d last %0b",
                 spike.target_index, $signed(spike.spike_weight), spike.last);
          errors++;
        end else begin
          want = pending_spikes.pop_front();
          if (spike.target_index !== want.target_index) begin
            $error("target_index: expected %0d, got %0d",
                   want.target_index, spike.target_index);
            errors++;
          end
          if (spike.spike_weight !== want.spike_weight) begin
            $error("spike_weight: expected %0d, got %0d",
                   $signed(want.spike_weight), $signed(spike.spike_weight));
            errors++;
          end
          if (spike.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, spike.last);
            errors++;
          end
        end
      end
    end
  end

  function automatic snf_pkg::item_t make_item(snf_pkg::op_t op,
                                               logic [snf_pkg::Q_W-1:0] amt,
                                               logic [2:0] idx);
    snf_pkg::item_t it;
    it.operation  = op;
    it.amount     = amt;
    it.link_index = idx;
    return it;
  endfunction

  // Mostly uniform amounts, with the Q8.8 extremes mixed in.
  function automatic logic [snf_pkg::Q_W-1:0] rand_amount();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
    return 16'($urandom);
  endfunction

  // Present one item and hold it until the transaction completes. Called
  // and returns at a rising edge; valid is lowered only on an idle cycle.
  task automatic send_item(input snf_pkg::item_t it);
    logic taken;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = item_ready;
      @(posedge clk);
    end
  endtask

  // Drop valid, wait for every predicted spike, then let the back end drain.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_spikes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write, mirrored into the local config. Trailing cycle keeps
  // back-to-back writes from raising and lowering the enable in one step.
  task automatic cfg_write(input snf_pkg::cfg_reg_t r, input logic [snf_pkg::Q_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      snf_pkg::REG_RESTING_LEVEL:    m_rest        = d;
      snf_pkg::REG_LEAK_STEP:        m_leak        = d[snf_pkg::LEAK_W-1:0];
      snf_pkg::REG_FIRE_THRESHOLD:   m_thr         = d;
      snf_pkg::REG_REFRACTORY_TICKS: m_refr_ticks  = d[snf_pkg::REFR_W-1:0];
      snf_pkg::REG_TICK_DRIVEN:      m_tick_driven = d[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Reset config, empty link table: ignored operation, tick at rest, and
  // firings on receive and on tick that produce no spikes.
  task automatic test_empty_fire();
    send_item(make_item(snf_pkg::OP_NONE, 16'h7FFF, 3'd7));
    send_item(make_item(snf_pkg::OP_TICK, 16'h0000, 3'd0));
    send_item(make_item(snf_pkg::OP_RECEIVE, 16'h0100, 3'd5));
    send_item(make_item(snf_pkg::OP_TICK, 16'hFFFF, 3'd2));
  endtask

  // Fill every link with extreme and patterned weights, saturate the
  // potential low, then raise it to fire the full fanout on receive.
  task automatic test_fanout_saturation();
    send_item(make_item(snf_pkg::OP_SET_LINK, 16'h8000, 3'd0));
    send_item(make_item(snf_pkg::OP_SET_LINK, 16'h7FFF, 3'd1));
    send_item(make_item(snf_pkg::OP_SET_LINK, 16'h0000, 3'd2));
    send_item(make_item(snf_pkg::OP_SET_LINK, 16'hFFFF, 3'd3));
    send_item(make_item(snf_pkg::OP_SET_LINK, 16'h5555, 3'd4));
    send_item(make_item(snf_pkg::OP_SET_LINK, 16'hAAAA, 3'd5));
    send_item(make_item(snf_pkg::OP_SET_LINK, 16'h0001, 3'd6));
    send_item(make_item(snf_pkg::OP_SET_LINK, 16'h1234, 3'd7));
    send_item(make_item(snf_pkg::OP_RECEIVE, 16'h8000, 3'd0));
    send_item(make_item(snf_pkg::OP_RECEIVE, 16'h8000, 3'd0));
    send_item(make_item(snf_pkg::OP_RECEIVE, 16'h7FFF, 3'd0));
    send_item(make_item(snf_pkg::OP_RECEIVE, 16'h7FFF, 3'd0));
  endtask

  // Tick-driven mode with a refractory count: receive never fires or counts
  // down, ticks count down and then fire. Resting level moves to its minimum
  // without touching the potential.
  task automatic test_tick_driven();
    settle();
    cfg_write(snf_pkg::REG_REFRACTORY_TICKS, 16'd2);
    cfg_write(snf_pkg::REG_TICK_DRIVEN, 16'd1);
    cfg_write(snf_pkg::REG_FIRE_THRESHOLD, 16'd100);
    cfg_write(snf_pkg::REG_RESTING_LEVEL, 16'h8000);
    cfg_write(snf_pkg::REG_LEAK_STEP, 16'h7FFF);
    send_item(make_item(snf_pkg::OP_RECEIVE, 16'h0001, 3'd0));
    send_item(make_item(snf_pkg::OP_TICK, 16'h0000, 3'd0));
    send_item(make_item(snf_pkg::OP_TICK, 16'h0000, 3'd0));
    send_item(make_item(snf_pkg::OP_RECEIVE, 16'hFFFF, 3'd0));
    send_item(make_item(snf_pkg::OP_TICK, 16'h0000, 3'd0));
    send_item(make_item(snf_pkg::OP_TICK, 16'h0000, 3'd0));
  endtask

  // Refractory countdown on receive, firing exactly at threshold, and a
  // full-size leak that clamps at rest from above and from below.
  task automatic test_refractory_and_leak();
    settle();
    cfg_write(snf_pkg::REG_TICK_DRIVEN, 16'd0);
    cfg_write(snf_pkg::REG_FIRE_THRESHOLD, 16'h7FFF);
    cfg_write(snf_pkg::REG_RESTING_LEVEL, 16'd1000);
    send_item(make_item(snf_pkg::OP_RECEIVE, 16'h0001, 3'd0));
    send_item(make_item(snf_pkg::OP_RECEIVE, 16'h0000, 3'd0));
    send_item(make_item(snf_pkg::OP_RECEIVE, 16'h0000, 3'd0));
    send_item(make_item(snf_pkg::OP_TICK, 16'h0000, 3'd0));
    send_item(make_item(snf_pkg::OP_TICK, 16'h0000, 3'd0));
    send_item(make_item(snf_pkg::OP_TICK, 16'h0000, 3'd0));
    send_item(make_item(snf_pkg::OP_RECEIVE, 16'hB1E0, 3'd0));
    send_item(make_item(snf_pkg::OP_TICK, 16'h0000, 3'd0));
  endtask

  // Random traffic in phases, each under its own config: both extremes first,
  // then random settings. Each phase rewrites part of the link table, then
  // mixes receives, ticks, link writes and a few ignored items.
  task automatic test_random_traffic();
    int           counted;
    int           pick;
    snf_pkg::op_t op;
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: begin
          cfg_write(snf_pkg::REG_RESTING_LEVEL, 16'h8000);
          cfg_write(snf_pkg::REG_LEAK_STEP, 16'h0000);
          cfg_write(snf_pkg::REG_FIRE_THRESHOLD, 16'h8000);
          cfg_write(snf_pkg::REG_REFRACTORY_TICKS, 16'd0);
          cfg_write(snf_pkg::REG_TICK_DRIVEN, 16'd0);
        end
        1: begin
          cfg_write(snf_pkg::REG_RESTING_LEVEL, 16'h7FFF);
          cfg_write(snf_pkg::REG_LEAK_STEP, 16'h7FFF);
          cfg_write(snf_pkg::REG_FIRE_THRESHOLD, 16'h7FFF);
          cfg_write(snf_pkg::REG_REFRACTORY_TICKS, 16'd255);
          cfg_write(snf_pkg::REG_TICK_DRIVEN, 16'd1);
        end
        default: begin
          cfg_write(snf_pkg::REG_RESTING_LEVEL, 16'($urandom));
          cfg_write(snf_pkg::REG_LEAK_STEP, 16'($urandom));
          cfg_write(snf_pkg::REG_FIRE_THRESHOLD, 16'($urandom));
          cfg_write(snf_pkg::REG_REFRACTORY_TICKS, 16'($urandom_range(3)));
          cfg_write(snf_pkg::REG_TICK_DRIVEN, 16'($urandom_range(1)));
        end
      endcase
      // Hold both channels busy for one whole phase.
      no_idle = (ph == 2);
      counted = $urandom_range(1, snf_pkg::MAX_LINKS);
      for (int n = 0; n < counted; n++) begin
        send_item(make_item(snf_pkg::OP_SET_LINK, rand_amount(), 3'($urandom_range(7))));
      end
      while (counted < 14) begin
        pick = $urandom_range(99);
        if (pick < 45) op = snf_pkg::OP_RECEIVE;
        else if (pick < 80) op = snf_pkg::OP_TICK;
        else if (pick < 92) op = snf_pkg::OP_SET_LINK;
        else op = snf_pkg::OP_NONE;
        send_item(make_item(op, rand_amount(), 3'($urandom_range(7))));
        // Ignored items do not advance the phase.
        if (op != snf_pkg::OP_NONE) counted++;
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_fire();
    test_fanout_saturation();
    test_tick_driven();
    test_refractory_and_leak();
    test_random_traffic();
    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
rtl/snf_pkg.sv
rtl/snf_ram.sv
rtl/snf_front.sv
rtl/snf_queue.sv
rtl/snf_back.sv
rtl/spiking_neuron_with_fanout.sv
sim/tb_spiking_neuron_with_fanout.sv
